// ----- sv/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by every scheduler module.
`default_nettype none

package rrts_pkg;

  localparam int NUM_TASKS_DEF = 16;

  localparam logic [13:0] HZ_RESET    = 14'd1000;
  localparam logic [15:0] SLICE_RESET = 16'd10;

  // Round-up term and reciprocal of 1000 for the ms to tick conversion
  localparam logic [31:0] ROUND_UP    = 32'd999;
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  localparam logic CFG_TIMER_HZ    = 1'b0;
  localparam logic CFG_SLICE_TICKS = 1'b1;

  typedef enum logic [2:0] {
    REQ_START = 3'd0,
    REQ_YIELD = 3'd1,
    REQ_SLEEP = 3'd2,
    REQ_BLOCK = 3'd3,
    REQ_WAKE  = 3'd4,
    REQ_EXIT  = 3'd5,
    REQ_TICK  = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_BLOCKED  = 3'd4,
    ST_ZOMBIE   = 3'd5
  } task_st_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_PEND = 2'd1,
    STAT_REJ  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LATCH = 3'd1,
    OP_MUL1  = 3'd2,
    OP_MUL2  = 3'd3,
    OP_EXEC  = 3'd4,
    OP_SCAN  = 3'd5,
    OP_SLICE = 3'd6,
    OP_PICK  = 3'd7
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_DECODE = 4'd1,
    S_MUL1   = 4'd2,
    S_MUL2   = 4'd3,
    S_EXEC   = 4'd4,
    S_SCAN   = 4'd5,
    S_SLICE  = 4'd6,
    S_PICK   = 4'd7,
    S_DONE   = 4'd8
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic sleep_go;
    logic pick_go;
    logic scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/round_robin_task_scheduler.sv -----
// Round-robin task scheduler, top level: sequencer plus datapath.
// From accept to done_o an event passes decode and execute; a reschedule adds a pick
// step, a sleep adds two multiply steps, and a tick adds a sleeper scan and a slice step.
// The tick's sleeper scan makes one wake-time memory read per slot.
// The next event can be taken in the cycle after done_o.
// One event at a time; the receiver cannot stall. Reset: slot 0 runs, rest free.
`default_nettype none

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  task_index_i,
  input  wire logic [15:0] sleep_ms_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic [4:0]       running_task_o,
  output logic             switched_o,
  output logic [1:0]       status_o,
  output logic [4:0]       ready_count_o
);

  // Command and status bundles between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy_int;

  // A beat is taken when start is high and the sequencer is idle; the sequencer
  // only looks at start in its idle state, where busy is low.
  rrts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_int),
    .done_o  (done_o)
  );

  rrts_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .task_index_i   (task_index_i),
    .sleep_ms_i     (sleep_ms_i),
    .running_task_o (running_task_o),
    .switched_o     (switched_o),
    .status_o       (status_o),
    .ready_count_o  (ready_count_o)
  );

  assign busy = busy_int;

endmodule

`default_nettype wire

// ----- sv/rrts_ctrl.sv -----
// Sequencer for the scheduler: steps the datapath through one event.
// Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = sts_i.sleep_go ? S_MUL1 : S_EXEC;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        if (sts_i.is_tick) begin
          state_d = S_SCAN;
        end else if (sts_i.pick_go) begin
          state_d = S_PICK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.scan_last) begin
          state_d = S_SLICE;
        end
      end
      S_SLICE: begin
        cmd_o.op = OP_SLICE;
        state_d  = S_PICK;
      end
      S_PICK: begin
        cmd_o.op = OP_PICK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/rrts_dp.sv -----
// Scheduler datapath: task table, ready queue and wake-time memories,
// clock, slice counter and sleep-time arithmetic. Depends on rrts_pkg.
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [3:0]  task_index_i,
  input  wire logic [15:0] sleep_ms_i,
  output logic [4:0]       running_task_o,
  output logic             switched_o,
  output logic [1:0]       status_o,
  output logic [4:0]       ready_count_o
);

  localparam int SlotW = $clog2(NUM_TASKS);
  localparam int CurW  = $clog2(NUM_TASKS + 1);
  localparam logic [CurW-1:0]  IdleTask = CurW'(NUM_TASKS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_TASKS - 1);

  // Event registers
  req_e              req_q, req_d;
  logic [3:0]        idx_q, idx_d;
  logic [15:0]       ms_q, ms_d;
  logic [CurW-1:0]   before_q, before_d;
  stat_e             status_q, status_d;
  logic [29:0]       prod_q, prod_d;
  logic [62:0]       quot_q, quot_d;
  logic [CurW-1:0]   scan_q, scan_d;

  // Scheduler state
  task_st_e          state_q [NUM_TASKS];
  task_st_e          state_d [NUM_TASKS];
  logic [NUM_TASKS-1:0] pend_q, pend_d;
  logic [SlotW-1:0]  head_q, head_d;
  logic [CurW-1:0]   count_q, count_d;
  logic [CurW-1:0]   cur_q, cur_d;
  logic [15:0]       slice_q, slice_d;
  logic [63:0]       now_q, now_d;
  logic [13:0]       hz_q;
  logic [15:0]       slc_q;

  // Ready queue and wake-time memories
  logic [SlotW-1:0]  fifo_mem [NUM_TASKS];
  logic [SlotW-1:0]  fifo_rd_q;
  logic              fifo_we;
  logic [SlotW-1:0]  fifo_waddr, fifo_wdata;
  logic [63:0]       wake_mem [NUM_TASKS];
  logic [63:0]       wake_rd_q;
  logic              wake_we;
  logic [63:0]       wake_wdata;
  logic [SlotW-1:0]  wake_raddr;

  logic              cur_idle, cur_running, pend_cur, idx_ok;
  logic [SlotW-1:0]  cur_slot, idx_slot, head_inc, tail, scan_slot;
  logic [CurW:0]     tail_sum;
  logic              push_en, pick_en;
  logic [SlotW-1:0]  push_slot;

  assign cur_idle    = (cur_q == IdleTask);
  assign cur_slot    = cur_idle ? '0 : SlotW'(cur_q);
  assign cur_running = cur_idle || (state_q[cur_slot] == ST_RUNNING);
  assign pend_cur    = !cur_idle && pend_q[cur_slot];
  assign idx_ok      = (32'(idx_q) < NUM_TASKS);
  assign idx_slot    = idx_ok ? SlotW'(idx_q) : '0;
  assign head_inc    = (head_q == LastSlot) ? '0 : head_q + 1'b1;
  assign tail_sum    = (CurW+1)'(head_q) + (CurW+1)'(count_q);
  assign tail        = (tail_sum >= (CurW+1)'(NUM_TASKS)) ?
                       SlotW'(tail_sum - (CurW+1)'(NUM_TASKS)) : SlotW'(tail_sum);
  assign scan_slot   = (scan_q == '0) ? '0 : SlotW'(scan_q - 1'b1);
  assign wake_raddr  = (scan_q < IdleTask) ? SlotW'(scan_q) : '0;

  assign sts_o.is_tick   = (req_q == REQ_TICK);
  assign sts_o.sleep_go  = (req_q == REQ_SLEEP) && !cur_idle && !pend_cur;
  assign sts_o.pick_go   = (req_q == REQ_YIELD) ||
                           ((req_q == REQ_SLEEP || req_q == REQ_BLOCK) &&
                            !cur_idle && !pend_cur) ||
                           ((req_q == REQ_EXIT) && !cur_idle);
  assign sts_o.scan_last = (scan_q == IdleTask);

  assign running_task_o = 5'(cur_q);
  assign switched_o     = (cur_q != before_q);
  assign status_o       = status_q;
  assign ready_count_o  = 5'(count_q);

  always_comb begin
    req_d      = req_q;
    idx_d      = idx_q;
    ms_d       = ms_q;
    before_d   = before_q;
    status_d   = status_q;
    prod_d     = prod_q;
    quot_d     = quot_q;
    scan_d     = scan_q;
    state_d    = state_q;
    pend_d     = pend_q;
    head_d     = head_q;
    count_d    = count_q;
    cur_d      = cur_q;
    slice_d    = slice_q;
    now_d      = now_q;
    fifo_we    = 1'b0;
    fifo_waddr = tail;
    fifo_wdata = '0;
    wake_we    = 1'b0;
    wake_wdata = now_q + 64'(quot_q[62:RECIP_SHIFT]);
    push_en    = 1'b0;
    push_slot  = '0;
    pick_en    = 1'b0;

    case (cmd_i.op)
      OP_LATCH: begin
        req_d    = req_e'(req_type_i);
        idx_d    = task_index_i;
        ms_d     = sleep_ms_i;
        before_d = cur_q;
        status_d = STAT_DONE;
        scan_d   = '0;
      end
      OP_MUL1: begin
        prod_d = 30'(ms_q) * 30'(hz_q);
      end
      OP_MUL2: begin
        quot_d = 63'(32'(prod_q) + ROUND_UP) * 63'(RECIP_1000);
      end
      OP_EXEC: begin
        case (req_q)
          REQ_START: begin
            if (!idx_ok || (state_q[idx_slot] != ST_FREE &&
                            state_q[idx_slot] != ST_ZOMBIE)) begin
              status_d = STAT_REJ;
            end else begin
              pend_d[idx_slot] = 1'b0;
              push_en          = 1'b1;
              push_slot        = idx_slot;
            end
          end
          REQ_YIELD: begin
          end
          REQ_SLEEP, REQ_BLOCK: begin
            if (cur_idle) begin
              status_d = STAT_REJ;
            end else if (pend_cur) begin
              pend_d[cur_slot] = 1'b0;
              status_d         = STAT_PEND;
            end else if (req_q == REQ_SLEEP) begin
              state_d[cur_slot] = ST_SLEEPING;
              wake_we           = 1'b1;
            end else begin
              state_d[cur_slot] = ST_BLOCKED;
            end
          end
          REQ_WAKE: begin
            if (!idx_ok || state_q[idx_slot] == ST_FREE) begin
              status_d = STAT_REJ;
            end else if (state_q[idx_slot] == ST_BLOCKED ||
                         state_q[idx_slot] == ST_SLEEPING) begin
              push_en   = 1'b1;
              push_slot = idx_slot;
            end else if (state_q[idx_slot] != ST_ZOMBIE) begin
              pend_d[idx_slot] = 1'b1;
            end
          end
          REQ_EXIT: begin
            if (cur_idle) begin
              status_d = STAT_REJ;
            end else begin
              state_d[cur_slot] = ST_ZOMBIE;
            end
          end
          REQ_TICK: begin
            now_d = now_q + 64'd1;
          end
          default: begin
            status_d = STAT_REJ;
          end
        endcase
      end
      OP_SCAN: begin
        // compare the slot whose wake time was read last cycle
        if (scan_q != '0 && state_q[scan_slot] == ST_SLEEPING &&
            wake_rd_q <= now_q) begin
          push_en   = 1'b1;
          push_slot = scan_slot;
        end
        scan_d = scan_q + 1'b1;
      end
      OP_SLICE: begin
        if (slice_q != '0) begin
          slice_d = slice_q - 16'd1;
        end
      end
      OP_PICK: begin
        pick_en = (req_q != REQ_TICK) ||
                  ((count_q != '0) && (slice_q == '0 || cur_idle));
      end
      default: begin
      end
    endcase

    if (push_en && count_q < IdleTask) begin
      state_d[push_slot] = ST_READY;
      fifo_we            = 1'b1;
      fifo_wdata         = push_slot;
      count_d            = count_q + 1'b1;
    end

    if (pick_en && !(count_q == '0 && cur_running)) begin
      if (count_q != '0) begin
        head_d = head_inc;
        count_d = count_q - 1'b1;
        // requeue the preempted task at the old tail
        if (!cur_idle && state_q[cur_slot] == ST_RUNNING) begin
          state_d[cur_slot] = ST_READY;
          fifo_we           = 1'b1;
          fifo_wdata        = cur_slot;
          count_d           = count_q;
        end
        state_d[fifo_rd_q] = ST_RUNNING;
        cur_d              = CurW'(fifo_rd_q);
      end else begin
        cur_d = IdleTask;
      end
      slice_d = slc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        state_q[i] <= ST_FREE;
      end
      state_q[0] <= ST_RUNNING;
      pend_q     <= '0;
      head_q     <= '0;
      count_q    <= '0;
      cur_q      <= '0;
      slice_q    <= SLICE_RESET;
      now_q      <= '0;
      hz_q       <= HZ_RESET;
      slc_q      <= SLICE_RESET;
      req_q      <= REQ_START;
      status_q   <= STAT_DONE;
      before_q   <= '0;
      scan_q     <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      head_q   <= head_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      slice_q  <= slice_d;
      now_q    <= now_d;
      req_q    <= req_d;
      status_q <= status_d;
      before_q <= before_d;
      scan_q   <= scan_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMER_HZ) begin
          hz_q <= cfg_data_i[13:0];
        end else begin
          slc_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_d_hold: begin
    end
    idx_q  <= idx_d;
    ms_q   <= ms_d;
    prod_q <= prod_d;
    quot_q <= quot_d;
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_rd_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (wake_we) begin
      wake_mem[cur_slot] <= wake_wdata;
    end
    wake_rd_q <= wake_mem[wake_raddr];
  end

endmodule

`default_nettype wire

// ----- sv/rrts_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module rrts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic       switched_o
);

  // result beat only while an event is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  // accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // one result per event, then back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o) else $error("done not followed by idle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status code");

  // a rejected event never switches tasks
  a_rej_noswitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == 2'd2) |-> !switched_o) else $error("reject switched");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .switched_o (switched_o)
);

`default_nettype wire
